>>> sv/csf_pkg.sv
// Shared types, constants and helpers for the case-insensitive substring finder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package csf_pkg;

  // Pattern capacity in bytes and width of the per-string byte counter
  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 16;

  // Fixed widths of the ports
  localparam int BYTE_BITS      = 8;
  localparam int MATCH_BITS     = 16;
  localparam int LEN_BITS       = 5;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;

  // Bytes held in each pattern word register
  localparam int WORD_BYTES = CFG_DATA_BITS / BYTE_BITS;

  // Window index width
  localparam int WIN_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Result queue depth, a power of two
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

  // Search configuration as seen by the front end
  typedef struct packed {
    logic [2*WORD_BYTES-1:0][BYTE_BITS-1:0] pattern;
    logic [LEN_BITS-1:0]                    length;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic                  found;
    logic [MATCH_BITS-1:0] match_start;
  } result_t;

  // Fold ASCII upper case to lower case, leave everything else alone
  function automatic logic [BYTE_BITS-1:0] fold_case(input logic [BYTE_BITS-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/case_insensitive_substring_find.sv
// Top level of the case-insensitive substring finder: configuration
// registers, front end and result queue. Uses csf_pkg, csf_front, csf_queue.
`default_nettype none

// Takes one text byte per cycle while full is low; a string ends with last_byte set. ASCII
// letters are compared without regard to case. Each string gives exactly one
// result: found with the start offset as soon as the first match completes,
// or not found at the last byte. A result is written into the result queue
// when the byte that caused it is transferred. The window compare is combinational,
// so a byte can follow every cycle; full rises only when the
// four-entry result queue holds four untaken results. Program the pattern
// registers only while no string is in flight.
module case_insensitive_substring_find (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic [csf_pkg::BYTE_BITS-1:0]          text_byte,
  input  wire logic                                   last_byte,
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic                                        found,
  output logic [csf_pkg::MATCH_BITS-1:0]              match_start,
  input  wire logic                                   cfg_write,
  input  wire logic [csf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [csf_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import csf_pkg::*;

  logic [CFG_DATA_BITS-1:0] pattern_low;
  logic [CFG_DATA_BITS-1:0] pattern_high;
  logic [LEN_BITS-1:0]      pattern_length;

  cfg_t    cfg;
  logic    in_valid;
  logic    result_valid;
  result_t result;
  result_t head;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pattern_high, pattern_low};
  assign cfg.length  = pattern_length;
  assign in_valid    = push && !full;

  csf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_byte      (text_byte),
    .in_last      (last_byte),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  csf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (result_valid),
    .wr_data  (result),
    .rd_en    (pop),
    .rd_data  (head),
    .is_full  (full),
    .is_empty (empty)
  );

  assign found       = head.found;
  assign match_start = head.match_start;

  // A full queue always has something to give
  a_full_not_empty: assert property (@(posedge clk) full |-> !empty)
    else $error("queue reports full and empty together");

  // The front end never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !full)
    else $error("result pushed while queue is full");

  // A not-found result carries a zero offset
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (match_start == '0))
    else $error("not-found result with nonzero offset");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results waiting after reset");

endmodule

`default_nettype wire

>>> sv/csf_front.sv
// Front end of the substring finder: folds case, keeps the byte window,
// position count and done flag, and classifies each byte. Uses csf_pkg.
`default_nettype none

module csf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire csf_pkg::cfg_t      cfg,
  output logic                    result_valid,
  output csf_pkg::result_t        result
);
  import csf_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] window;
  logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] window_next;
  logic [POSITION_BITS-1:0]              position;
  logic                                  done;

  logic [BYTE_BITS-1:0]     folded;
  logic [LEN_BITS-1:0]      eff_len;
  logic                     reached;
  logic                     all_equal;
  logic                     hit;
  logic [POSITION_BITS-1:0] start;

  // Clamp the length to the pattern capacity
  assign eff_len = (cfg.length > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                         : cfg.length;
  assign folded  = fold_case(in_byte);

  // Window as it stands once the new byte has shifted in
  always_comb begin
    window_next[0] = folded;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_next[j] = window[j-1];
    end
  end

  // Compare pattern byte k against the window entry len-1-k
  always_comb begin
    logic [LEN_BITS-1:0] sel;
    all_equal = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sel = eff_len - LEN_BITS'(k + 1);
      if (LEN_BITS'(k) < eff_len) begin
        if (fold_case(cfg.pattern[k]) != window_next[sel[WIN_IDX_BITS-1:0]]) begin
          all_equal = 1'b0;
        end
      end
    end
  end

  // Enough bytes seen for a full pattern
  assign reached = ((POSITION_BITS+1)'(position) + 1'b1) >= (POSITION_BITS+1)'(eff_len);
  assign start   = position - POSITION_BITS'(eff_len) + 1'b1;

  // Classify: match, end of string without match, or nothing
  always_comb begin
    hit                = 1'b0;
    result.found       = 1'b0;
    result.match_start = '0;
    if (eff_len == '0) begin
      hit                = 1'b1;
      result.found       = 1'b1;
      result.match_start = MATCH_BITS'(position);
    end else if (reached && all_equal) begin
      hit                = 1'b1;
      result.found       = 1'b1;
      result.match_start = MATCH_BITS'(start);
    end
    result_valid = in_valid && !done && (hit || in_last);
  end

  // Advance string state on each accepted byte; drop it at the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      position <= '0;
      done     <= 1'b0;
    end else if (in_valid) begin
      if (in_last) begin
        window   <= '0;
        position <= '0;
        done     <= 1'b0;
      end else begin
        window <= window_next;
        if (position < POS_MAX) begin
          position <= position + 1'b1;
        end
        if (!done && hit) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/csf_queue.sv
// Back end of the substring finder: a short result queue that holds
// classified results until the consumer takes them. Uses csf_pkg.
`default_nettype none

module csf_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire csf_pkg::result_t  wr_data,
  input  wire logic              rd_en,
  output csf_pkg::result_t       rd_data,
  output logic                   is_full,
  output logic                   is_empty
);
  import csf_pkg::*;

  result_t [QUEUE_DEPTH-1:0]  entries;
  logic [QUEUE_PTR_BITS-1:0]  wr_ptr;
  logic [QUEUE_PTR_BITS-1:0]  rd_ptr;
  logic [QUEUE_CNT_BITS-1:0]  count;
  logic                       do_wr;
  logic                       do_rd;

  assign is_full  = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && !is_empty;
  assign rd_data  = entries[rd_ptr];

  // Store pushed results; payload needs no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> test/csf_checker.sv
// Scoreboard for the case-insensitive substring finder: mirrors the search on
// every input transfer, queues the expected results and compares each result
// transfer against them. Depends on csf_pkg for widths, indexes and result_t.

module csf_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  full,
  input  logic [csf_pkg::BYTE_BITS-1:0]         text_byte,
  input  logic                                  last_byte,
  input  logic                                  empty,
  input  logic                                  pop,
  input  logic                                  found,
  input  logic [csf_pkg::MATCH_BITS-1:0]        match_start,
  input  logic                                  cfg_write,
  input  logic [csf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [csf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output int                                    errors,
  output int                                    pending,
  output int                                    hits,
  output int                                    misses
);

  localparam int WIN = csf_pkg::MAX_PATTERN;

  // Mirrored search state and configuration
  logic [csf_pkg::BYTE_BITS-1:0]       window [WIN];
  logic [csf_pkg::POSITION_BITS-1:0]   pos;
  logic                                matched;
  logic [2*csf_pkg::CFG_DATA_BITS-1:0] pat;
  logic [csf_pkg::LEN_BITS-1:0]        pat_len;

  csf_pkg::result_t due_results [$];
  csf_pkg::result_t want;
  int fail_count = 0;
  int hit_count = 0;
  int miss_count = 0;
  int result_index = 0;

  assign errors = fail_count;
  assign hits   = hit_count;
  assign misses = miss_count;

  initial pending = 0;

  // ASCII upper case maps to lower case, all other bytes pass through
  function automatic logic [csf_pkg::BYTE_BITS-1:0] lower_ascii(
    input logic [csf_pkg::BYTE_BITS-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // Count a failure, show only the first few
  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Forget the current string
  task automatic clear_string_state();
    int k;
    for (k = 0; k < WIN; k++) begin
      window[k] = '0;
    end
    pos = '0;
    matched = 1'b0;
  endtask

  // Advance the search by one text byte and queue any result it causes
  task automatic predict_search(input logic [csf_pkg::BYTE_BITS-1:0] raw, input logic fin);
    logic [csf_pkg::BYTE_BITS-1:0]  b;
    logic [csf_pkg::MATCH_BITS-1:0] start;
    logic                           hit;
    csf_pkg::result_t               r;
    int n;
    int k;
    b = lower_ascii(raw);
    n = (int'(pat_len) > WIN) ? WIN : int'(pat_len);
    for (k = WIN - 1; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = b;
    if (!matched) begin
      hit = 1'b0;
      start = '0;
      if (n == 0) begin
        hit = 1'b1;
        start = pos;
      end else if (int'(pos) + 1 >= n) begin
        hit = 1'b1;
        for (k = 0; k < n; k++) begin
          if (lower_ascii(pat[k*8 +: 8]) != window[n-1-k]) begin
            hit = 1'b0;
          end
        end
        start = pos - (n - 1);
      end
      if (hit) begin
        r.found = 1'b1;
        r.match_start = start;
        due_results.push_back(r);
        matched = 1'b1;
        hit_count++;
      end else if (fin) begin
        r.found = 1'b0;
        r.match_start = '0;
        due_results.push_back(r);
        miss_count++;
      end
    end
    // Saturate the position count
    if (pos != '1) begin
      pos++;
    end
    if (fin) begin
      clear_string_state();
    end
  endtask

  // Compare result transfers first, then predict, then take register writes
  always @(posedge clk) begin
    if (rst) begin
      clear_string_state();
      pat = '0;
      pat_len = '0;
      due_results.delete();
    end else begin
      if (pop && !empty) begin
        result_index++;
        if (due_results.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing expected: found=%0d start=%0d",
                         result_index, found, match_start));
        end else begin
          want = due_results.pop_front();
          if (found !== want.found || match_start !== want.match_start) begin
            flag($sformatf("result %0d mismatch: expected found=%0d start=%0d, got found=%0d start=%0d",
                           result_index, want.found, want.match_start, found, match_start));
          end
        end
      end
      if (push && !full) begin
        predict_search(text_byte, last_byte);
      end
      if (cfg_write) begin
        case (cfg_index)
          csf_pkg::REG_PATTERN_LOW: begin
            pat[csf_pkg::CFG_DATA_BITS-1:0] = cfg_data;
          end
          csf_pkg::REG_PATTERN_HIGH: begin
            pat[2*csf_pkg::CFG_DATA_BITS-1:csf_pkg::CFG_DATA_BITS] = cfg_data;
          end
          csf_pkg::REG_PATTERN_LEN: begin
            pat_len = cfg_data[csf_pkg::LEN_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    pending <= due_results.size();
  end

endmodule

>>> test/tb.sv
// Testbench top for case_insensitive_substring_find: clock, reset, pattern
// programming, text stimulus and result-side stalls. Uses csf_pkg, the block
// and csf_checker, which predicts and compares.

module tb;

  localparam int LIMIT        = 1_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LONG_FILL    = 40;
  localparam logic [csf_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic last_byte = 1'b0;
  logic pop = 1'b0;
  logic cfg_write = 1'b0;
  logic [csf_pkg::BYTE_BITS-1:0]      text_byte = '0;
  logic [csf_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [csf_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  wire                          full;
  wire                          empty;
  wire                          found;
  wire [csf_pkg::MATCH_BITS-1:0] match_start;

  int errors;
  int pending;
  int hits;
  int misses;

  bit steady = 1'b0;
  int cycles = 0;
  int byte_total = 0;
  int string_total = 0;
  int pattern_total = 0;

  // Pattern as currently programmed, used to shape the text
  logic [7:0] pat_now [16];
  int         len_now = 0;
  logic [7:0] txt [$];

  case_insensitive_substring_find u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .last_byte   (last_byte),
    .empty       (empty),
    .pop         (pop),
    .found       (found),
    .match_start (match_start),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  csf_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .last_byte   (last_byte),
    .empty       (empty),
    .pop         (pop),
    .found       (found),
    .match_start (match_start),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .hits        (hits),
    .misses      (misses)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("case_insensitive_substring_find verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Bytes near the case-folding boundaries plus a few extremes
  function automatic logic [7:0] set_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'h61;
      2:       return 8'h41;
      3:       return 8'h40;
      4:       return 8'h60;
      5:       return 8'h7A;
      6:       return 8'h5A;
      7:       return 8'h5B;
      8:       return 8'h7B;
      9:       return 8'hFF;
      10:      return 8'hC1;
      default: return 8'hE1;
    endcase
  endfunction

  // Flip the case of a letter at random
  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // Byte likely to take part in a partial or full match
  function automatic logic [7:0] near_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && len_now > 0) begin
      return flip_case(pat_now[$urandom_range(0, len_now - 1)]);
    end else if (r < 80) begin
      return set_byte();
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one byte and hold it until it transfers, then maybe idle
  task automatic put_byte(input logic [7:0] b, input logic fin);
    push <= 1'b1;
    text_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    byte_total++;
    if (!steady && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Send the queued text as one string
  task automatic send_txt();
    int k;
    for (k = 0; k < txt.size(); k++) begin
      put_byte(txt[k], k == txt.size() - 1);
    end
    string_total++;
  endtask

  // Drain all due results and let the block go quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program both pattern words, optionally the unused index, then the length
  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input bit spare);
    logic [63:0] lw;
    int k;
    lw = {$urandom, $urandom};
    lw[4:0] = len;
    cfg_write <= 1'b1;
    cfg_index <= csf_pkg::REG_PATTERN_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= csf_pkg::REG_PATTERN_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    if (spare) begin
      cfg_index <= REG_SPARE;
      cfg_data <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_index <= csf_pkg::REG_PATTERN_LEN;
    cfg_data <= lw;
    @(posedge clk);
    cfg_write <= 1'b0;
    for (k = 0; k < 8; k++) begin
      pat_now[k] = lo[k*8 +: 8];
      pat_now[k+8] = hi[k*8 +: 8];
    end
    len_now = (len > 5'd16) ? 16 : int'(len);
    pattern_total++;
  endtask

  // Build one string: mostly an embedded, possibly damaged copy of the pattern
  task automatic make_text();
    int r;
    int k;
    int pre;
    int cnt;
    txt.delete();
    r = $urandom_range(0, 99);
    if (r < 60) begin
      pre = $urandom_range(0, 6);
      for (k = 0; k < pre; k++) txt.push_back(near_byte());
      for (k = 0; k < len_now; k++) txt.push_back(flip_case(pat_now[k]));
      if (len_now > 0 && $urandom_range(0, 9) < 3) begin
        k = pre + $urandom_range(0, len_now - 1);
        if ($urandom_range(0, 1) == 1) begin
          txt[k] = txt[k] ^ 8'h20;
        end else begin
          txt[k] = txt[k] ^ 8'($urandom_range(1, 255));
        end
      end
      cnt = $urandom_range(0, 4);
      for (k = 0; k < cnt; k++) txt.push_back(near_byte());
    end else if (r < 80) begin
      cnt = $urandom_range(1, 12);
      for (k = 0; k < cnt; k++) txt.push_back(near_byte());
    end else begin
      cnt = $urandom_range(1, 12);
      for (k = 0; k < cnt; k++) txt.push_back(8'($urandom_range(0, 255)));
    end
    if (txt.size() == 0) begin
      txt.push_back(near_byte());
    end
  endtask

  // Result side: accept when not stalled
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall = gap_len();
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int random_items;
    int phase_items;
    int phase_goal;
    int phase;
    int lenv;
    int k;
    logic [127:0] pv;
    for (k = 0; k < 16; k++) pat_now[k] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty pattern after reset: match on the first byte, rest absorbed
    txt = '{8'hFF};
    send_txt();
    txt = '{8'h00, 8'h41};
    send_txt();

    // Mixed case with a zero byte inside the pattern, then a too-short string
    settle();
    pv = {$urandom, $urandom, $urandom, $urandom};
    pv[23:0] = 24'h006948;
    load_pattern(pv[63:0], pv[127:64], 5'd3, 1'b0);
    txt = '{8'h78, 8'h68, 8'h49, 8'h00};
    send_txt();
    txt = '{8'h68, 8'h69};
    send_txt();

    // Overlong length on a full pattern of boundary bytes
    settle();
    load_pattern(64'h6D5B400080FF5A61, 64'hC17A417F017B6051, 5'd20, 1'b0);
    txt.delete();
    for (k = 0; k < 16; k++) begin
      txt.push_back(flip_case(pat_now[k]));
    end
    send_txt();

    // Random phases, each under a fresh pattern setting
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0:       lenv = 16;
        1:       lenv = 0;
        2:       lenv = 31;
        3:       lenv = 1;
        4:       lenv = 8;
        5:       lenv = 9;
        default: begin
          case ($urandom_range(0, 9))
            0:       lenv = $urandom_range(17, 31);
            1:       lenv = 0;
            default: lenv = $urandom_range(1, 16);
          endcase
        end
      endcase
      for (k = 0; k < 16; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          pv[k*8 +: 8] = 8'($urandom_range(0, 255));
        end else begin
          pv[k*8 +: 8] = set_byte();
        end
      end
      load_pattern(pv[63:0], pv[127:64], 5'(lenv), phase == 0 || $urandom_range(0, 4) == 0);
      steady = ($urandom_range(0, 4) == 0);
      phase_goal = $urandom_range(40, 150);
      phase_items = 0;
      while (phase_items < phase_goal) begin
        make_text();
        phase_items += txt.size();
        send_txt();
      end
      random_items += phase_items;
      phase++;
    end

    // One longer string sent back to back, match just before the last byte
    settle();
    pv = {$urandom, $urandom, $urandom, $urandom};
    pv[23:0] = 24'h517A51;
    load_pattern(pv[63:0], pv[127:64], 5'd3, 1'b0);
    steady = 1'b1;
    for (k = 0; k < LONG_FILL; k++) begin
      put_byte(8'($urandom_range(8'h30, 8'h39)), 1'b0);
    end
    put_byte(8'h71, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_byte(8'h71, 1'b0);
    put_byte(8'h21, 1'b1);
    string_total++;
    steady = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    $display("Searched %0d strings (%0d bytes) under %0d pattern settings",
             string_total, byte_total, pattern_total);
    $display("Checked %0d found and %0d not-found results", hits, misses);
    if (errors == 0 && pending == 0) begin
      $display("case_insensitive_substring_find verification clean");
    end else begin
      $display("case_insensitive_substring_find verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/csf_pkg.sv
sv/csf_front.sv
sv/csf_queue.sv
sv/case_insensitive_substring_find.sv
test/csf_checker.sv
test/tb.sv
